[rtl/wssd_pkg.sv]
// shared constants, types and reset values of the weigh-scale stability detector
`default_nettype none

package wssd_pkg;

  localparam int WINDOW    = 10;
  localparam int RAW_W     = 24;
  localparam int GAIN_W    = 32;
  localparam int BAND_W    = 24;
  localparam int RUNS_W    = 8;
  localparam int WEIGHT_W  = 32;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;

  localparam int NET_W     = RAW_W + 1;
  localparam int PROD_W    = NET_W + GAIN_W;
  localparam int FRAC_W    = 24;
  localparam int Q_W       = PROD_W - FRAC_W + 1;
  localparam int CNT_W     = $clog2(WINDOW + 1);
  localparam int SLOT_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUM_W     = WEIGHT_W + CNT_W;
  localparam int DIGIT_W   = 4;
  localparam int DIV_STEPS = (SUM_W + DIGIT_W - 1) / DIGIT_W;
  localparam int DIVN_W    = DIV_STEPS * DIGIT_W;
  localparam int STEP_W    = $clog2(NET_W + 1);
  localparam int DIFF_W    = WEIGHT_W + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ZERO_OFFSET = 2'd0,
    CFG_RECIP_GAIN  = 2'd1,
    CFG_STABLE_BAND = 2'd2,
    CFG_STABLE_RUNS = 2'd3
  } cfg_index_t;

  localparam logic [GAIN_W-1:0] RECIP_GAIN_RST  = 32'd386589;
  localparam logic [BAND_W-1:0] STABLE_BAND_RST = 24'd2560;
  localparam logic [RUNS_W-1:0] STABLE_RUNS_RST = 8'd3;

  localparam logic [RAW_W-1:0] RAW_POS_FULL = {1'b0, {(RAW_W-1){1'b1}}};
  localparam logic [RAW_W-1:0] RAW_NEG_FULL = {1'b1, {(RAW_W-1){1'b0}}};

  localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = {1'b0, {(WEIGHT_W-1){1'b1}}};
  localparam logic [WEIGHT_W-1:0] WEIGHT_MIN = {1'b1, {(WEIGHT_W-1){1'b0}}};

  localparam logic [RUNS_W-1:0] RUN_SAT = {RUNS_W{1'b1}};

  localparam logic EV_STABLE = 1'b0;
  localparam logic EV_LEFT   = 1'b1;

endpackage

`default_nettype wire

[rtl/wssd_stream_if.sv]
// valid/ready channels for raw samples and stability events
`default_nettype none

interface wssd_in_if import wssd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [RAW_W-1:0] raw_sample;

  modport source (output valid, output raw_sample, input ready);
  modport sink   (input valid, input raw_sample, output ready);
endinterface

interface wssd_out_if import wssd_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       event_kind;
  logic signed [WEIGHT_W-1:0] weight_q8;
  logic                       first_report;

  modport source (output valid, output event_kind, output weight_q8, output first_report,
                  input ready);
  modport sink   (input valid, input event_kind, input weight_q8, input first_report,
                  output ready);
endinterface

`default_nettype wire

[rtl/weigh_scale_stability_detector.sv]
// weigh-scale stability detector: tare, gain, moving average and stable/left events
// one sample passes accept, 25 shift-add multiply steps, 3 ring/sum steps,
// 9 radix-16 divide steps and 3 compare/decide steps; a saturated sample is dropped
// at accept; the result is registered in decide, which waits while an older result
// is still held at the output; no new sample is taken until decide returns to idle
// synchronous reset clears the ring fill, sum, run counter, flags and output valid
`default_nettype none

module weigh_scale_stability_detector import wssd_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  wssd_in_if.sink                   sample_in,
  wssd_out_if.source                result_out
);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_WGT, S_SUB, S_ADD, S_DIV, S_AVG, S_CMP, S_DECIDE
  } state_t;

  state_t state;

  // configuration
  logic signed [RAW_W-1:0] zero_offset;
  logic [GAIN_W-1:0]       recip_gain;
  logic [BAND_W-1:0]       stable_band;
  logic [RUNS_W-1:0]       stable_runs;

  // working registers
  logic [STEP_W-1:0]          step;
  logic                       w_neg;
  logic [GAIN_W-1:0]          hi;
  logic [NET_W-1:0]           lo;
  logic signed [WEIGHT_W-1:0] weight;
  logic                       div_neg;
  logic [DIVN_W-1:0]          divn;
  logic [CNT_W-1:0]           rem;
  logic signed [WEIGHT_W-1:0] avg;

  // filter and detector state
  logic signed [WEIGHT_W-1:0] ring [WINDOW];
  logic [SLOT_W-1:0]          write_slot;
  logic [CNT_W-1:0]           fill_count;
  logic signed [SUM_W-1:0]    window_sum;
  logic signed [WEIGHT_W-1:0] prev_average;
  logic [RUNS_W-1:0]          calm_run;
  logic                       stable_flag;
  logic signed [WEIGHT_W-1:0] held_weight;
  logic                       first_done;

  // output register
  logic                       out_valid;
  logic                       out_kind;
  logic signed [WEIGHT_W-1:0] out_weight;
  logic                       out_first;

  logic                    accept;
  logic                    raw_full;
  logic signed [NET_W-1:0] net;
  logic [NET_W-1:0]        net_mag;
  logic [GAIN_W:0]         mul_sum;
  logic [Q_W-1:0]          q;
  logic [WEIGHT_W-1:0]     w_val;
  logic signed [WEIGHT_W-1:0] old_entry;
  logic signed [SUM_W-1:0] sum_new;
  logic signed [SUM_W-1:0] sum_mag;
  logic [DIVN_W-1:0]       div_d;
  logic [CNT_W-1:0]        div_r;
  logic signed [WEIGHT_W-1:0] cmp_ref;
  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0]       diff_abs;
  logic                    out_free;
  logic                    avg_pos;
  logic                    rise;
  logic                    fall;
  logic                    emit;

  assign accept   = sample_in.valid && sample_in.ready;
  assign raw_full = (sample_in.raw_sample == RAW_POS_FULL) ||
                    (sample_in.raw_sample == RAW_NEG_FULL);
  assign net      = NET_W'(sample_in.raw_sample) - NET_W'(zero_offset);
  assign net_mag  = net[NET_W-1] ? NET_W'(-net) : NET_W'(net);

  // shift-add multiplier step
  assign mul_sum = {1'b0, hi} + (lo[0] ? {1'b0, recip_gain} : '0);

  // floor of product / 2^24, negative side rounds away via the sticky bits
  assign q = Q_W'({hi, lo[NET_W-1:FRAC_W]}) + Q_W'(w_neg && (|lo[FRAC_W-1:0]));

  always_comb begin
    if (w_neg) begin
      w_val = (q > Q_W'(WEIGHT_MIN)) ? WEIGHT_MIN : -q[WEIGHT_W-1:0];
    end else begin
      w_val = (q > Q_W'(WEIGHT_MAX)) ? WEIGHT_MAX : q[WEIGHT_W-1:0];
    end
  end

  // entries not yet filled count as zero; the ring itself is not reset
  assign old_entry = (fill_count < CNT_W'(WINDOW)) ? '0 : ring[write_slot];
  assign sum_new   = window_sum + SUM_W'(weight);
  assign sum_mag   = sum_new[SUM_W-1] ? -sum_new : sum_new;

  // one radix-16 digit of restoring division by the fill count
  always_comb begin
    logic [CNT_W:0]    t;
    logic [DIVN_W-1:0] d;
    logic [CNT_W-1:0]  r;
    d = divn;
    r = rem;
    for (int k = 0; k < DIGIT_W; k++) begin
      t = {r, d[DIVN_W-1]};
      d = {d[DIVN_W-2:0], 1'b0};
      if (t >= {1'b0, fill_count}) begin
        t    = t - {1'b0, fill_count};
        d[0] = 1'b1;
      end
      r = t[CNT_W-1:0];
    end
    div_d = d;
    div_r = r;
  end

  // shared difference unit: previous average while counting, held weight when deciding
  assign cmp_ref  = (state == S_CMP) ? prev_average : held_weight;
  assign diff     = DIFF_W'(avg) - DIFF_W'(cmp_ref);
  assign diff_abs = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);

  assign out_free = !out_valid || result_out.ready;
  assign avg_pos  = !avg[WEIGHT_W-1] && (avg != '0);

  assign rise = !stable_flag && (calm_run >= stable_runs);
  assign fall = stable_flag && (diff_abs > DIFF_W'(stable_band));
  assign emit = (state == S_DECIDE) && out_free && (rise || fall) && avg_pos;

  assign sample_in.ready         = (state == S_IDLE);
  assign result_out.valid        = out_valid;
  assign result_out.event_kind   = out_kind;
  assign result_out.weight_q8    = out_weight;
  assign result_out.first_report = out_first;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      zero_offset  <= '0;
      recip_gain   <= RECIP_GAIN_RST;
      stable_band  <= STABLE_BAND_RST;
      stable_runs  <= STABLE_RUNS_RST;
      write_slot   <= '0;
      fill_count   <= '0;
      window_sum   <= '0;
      prev_average <= '0;
      calm_run     <= '0;
      stable_flag  <= 1'b0;
      held_weight  <= '0;
      first_done   <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index_t'(cfg_index))
          CFG_ZERO_OFFSET: zero_offset <= cfg_data[RAW_W-1:0];
          CFG_RECIP_GAIN:  recip_gain  <= cfg_data[GAIN_W-1:0];
          CFG_STABLE_BAND: stable_band <= cfg_data[BAND_W-1:0];
          CFG_STABLE_RUNS: stable_runs <= cfg_data[RUNS_W-1:0];
          default: ;
        endcase
      end

      if (emit) begin
        out_valid <= 1'b1;
      end else if (result_out.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept && !raw_full) begin
            w_neg <= net[NET_W-1];
            hi    <= '0;
            lo    <= net_mag;
            step  <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          hi   <= mul_sum[GAIN_W:1];
          lo   <= {mul_sum[0], lo[NET_W-1:1]};
          step <= step + 1'b1;
          if (step == STEP_W'(NET_W - 1)) begin
            state <= S_WGT;
          end
        end
        S_WGT: begin
          weight <= w_val;
          state  <= S_SUB;
        end
        S_SUB: begin
          window_sum <= window_sum - SUM_W'(old_entry);
          state      <= S_ADD;
        end
        S_ADD: begin
          window_sum         <= sum_new;
          ring[write_slot]   <= weight;
          write_slot         <= (write_slot == SLOT_W'(WINDOW - 1)) ? '0 : write_slot + 1'b1;
          if (fill_count < CNT_W'(WINDOW)) begin
            fill_count <= fill_count + 1'b1;
          end
          div_neg <= sum_new[SUM_W-1];
          divn    <= DIVN_W'(sum_mag);
          rem     <= '0;
          step    <= '0;
          state   <= S_DIV;
        end
        S_DIV: begin
          divn <= div_d;
          rem  <= div_r;
          step <= step + 1'b1;
          if (step == STEP_W'(DIV_STEPS - 1)) begin
            state <= S_AVG;
          end
        end
        S_AVG: begin
          avg   <= div_neg ? -divn[WEIGHT_W-1:0] : divn[WEIGHT_W-1:0];
          state <= S_CMP;
        end
        S_CMP: begin
          if (diff_abs < DIFF_W'(stable_band)) begin
            if (calm_run != RUN_SAT) begin
              calm_run <= calm_run + 1'b1;
            end
          end else begin
            calm_run <= '0;
          end
          prev_average <= avg;
          state        <= S_DECIDE;
        end
        S_DECIDE: begin
          if (out_free) begin
            if (rise) begin
              stable_flag <= 1'b1;
              held_weight <= avg;
              if (avg_pos) begin
                out_kind   <= EV_STABLE;
                out_weight <= avg;
                out_first  <= !first_done;
                first_done <= 1'b1;
              end
            end else if (fall) begin
              stable_flag <= 1'b0;
              if (avg_pos) begin
                out_kind   <= EV_LEFT;
                out_weight <= avg;
                out_first  <= 1'b0;
              end
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
